### rtl/core/led_matrix_scan_driver_core_defines.svh
// Assertion macros for the checker file of the LED matrix scan driver.
// No dependencies; the using file supplies clk and rst_n.
`ifndef LED_MATRIX_SCAN_DRIVER_CORE_DEFINES_SVH
`define LED_MATRIX_SCAN_DRIVER_CORE_DEFINES_SVH

// Checked on every rising edge outside reset.
`define LMSD_ASSERT_CLK(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define LMSD_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/core/lmsd_pkg.sv
// Package for the LED matrix scan driver: sizes, codes and types.
// No dependencies; used by the top level.
package lmsd_pkg;

  localparam int LINE_COUNT   = 8;
  localparam int LINE_W       = 3;
  localparam int BITS_IN_LINE = 96;
  localparam int BIT_W        = 7;
  localparam int PLANE_COLS   = 32;
  localparam int COL_W        = 5;
  localparam int PLANES       = 3;
  localparam int PLANE_W      = 2;
  localparam int FRAME_DEPTH  = LINE_COUNT * PLANE_COLS;
  localparam int FRAME_AW     = LINE_W + COL_W;
  localparam int HOLD_W       = 16;
  localparam logic [HOLD_W-1:0] HOLD_RESET = 16'd2000;
  localparam int CFG_AW       = 2;
  localparam int CFG_DW       = 32;
  localparam logic [CFG_AW-1:0] REG_HOLD_TICKS = 2'd0;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_CLEAR = 2'd1,
    OP_TICK  = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    PH_SHIFT = 2'd0,
    PH_LATCH = 2'd1,
    PH_HOLD  = 2'd2,
    PH_END   = 2'd3
  } phase_t;

  typedef struct packed {
    logic [LINE_W-1:0]  rows;
    logic               shift;
    logic               latch;
    logic               blank;
    logic [PLANE_W-1:0] plane;
    logic               entry_valid;
  } scan_res_t;

endpackage

### rtl/core/lmsd_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module lmsd_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/core/led_matrix_scan_driver_core.sv
// Top level of the LED matrix scan driver: frame store and refresh sequencer.
// Depends on lmsd_pkg and lmsd_ram.
//
// Channel   Dir  Handshake          Contents
// in_       in   tvalid/tready      tuser opcode; tdata pixel_x, pixel_y, colour
// out_      out  tvalid/tready      tdata pin levels of one scan tick
// cfg_      in   APB psel/penable   hold_ticks at byte address 0
//
// One request is taken per cycle while stage one is free or advancing.
// The frame store RAM read is registered alongside stage one; the output register follows.
// Output register and stage-one register let one more request in while out stalls.
// Reset clears the scan state and the per-entry valid bits; no clearing pass runs.
module led_matrix_scan_driver_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [1:0]                  in_tuser,    // opcode
  input  logic [23:0]                 in_tdata,    // pixel_x, pixel_y, colour, zero pad
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [7:0]                  out_tdata,   // row_pins, serial_data,
                                                   // shift_clock, latch_pulse, blank, pad
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [lmsd_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [lmsd_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [lmsd_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                        cfg_pready
);
  import lmsd_pkg::*;

  logic [HOLD_W-1:0]      hold_ticks_r;
  phase_t                 phase_r, phase_nxt;
  logic [LINE_W-1:0]      line_r, line_nxt;
  logic [BIT_W-1:0]       bit_r, bit_nxt;
  logic [HOLD_W-1:0]      hold_r, hold_nxt;
  logic [HOLD_W-1:0]      hold_inc;
  logic                   last_line;
  logic                   go_next_line;
  scan_res_t              res;
  logic                   rd_en;
  logic [FRAME_AW-1:0]    rd_addr;
  logic [FRAME_DEPTH-1:0] ent_valid_r;
  logic                   s1_v_r;
  scan_res_t              s1_res_r;
  logic                   s1_adv;
  logic                   out_v_r;
  logic [7:0]             out_data_r;
  logic [PLANES-1:0]      ram_rdata;
  logic                   in_acc;
  logic                   tick;
  logic                   pix_we;
  logic                   clr;
  logic [FRAME_AW-1:0]    wr_addr;
  logic [PLANES-1:0]      wr_data;
  logic [7:0]             pixel_x;
  logic [7:0]             pixel_y;
  logic [2:0]             colour;
  logic                   serial;
  logic                   cfg_wr;

  assign pixel_x = in_tdata[7:0];
  assign pixel_y = in_tdata[15:8];
  assign colour  = in_tdata[18:16];

  assign in_acc = in_tvalid && in_tready;
  assign tick   = in_acc && (in_tuser == OP_TICK);
  assign clr    = in_acc && (in_tuser == OP_CLEAR);
  assign pix_we = in_acc && (in_tuser == OP_WRITE) &&
                  (pixel_x[7:4] == 4'd0) && (pixel_y[7:4] == 4'd0);

  // Each entry holds the three plane bits of one line column.
  assign wr_addr = {pixel_y[3:1], pixel_y[0], pixel_x[3:0]};
  assign wr_data = {colour[0], colour[2], colour[1]};
  assign rd_addr = {line_r, bit_r[COL_W-1:0]};

  lmsd_ram #(
    .WIDTH(PLANES),
    .DEPTH(FRAME_DEPTH)
  ) u_frame_ram (
    .clk  (clk),
    .we   (pix_we),
    .waddr(wr_addr),
    .wdata(wr_data),
    .re   (rd_en),
    .raddr(rd_addr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      ent_valid_r <= '0;
    end else if (pix_we) begin
      ent_valid_r[wr_addr] <= 1'b1;
    end
  end

  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == REG_HOLD_TICKS) ?
                      CFG_DW'(hold_ticks_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_ticks_r <= HOLD_RESET;
    end else if (cfg_wr && (cfg_paddr == REG_HOLD_TICKS)) begin
      hold_ticks_r <= cfg_pwdata[HOLD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SHIFT;
      line_r  <= '0;
      bit_r   <= '0;
      hold_r  <= '0;
    end else if (tick) begin
      phase_r <= phase_nxt;
      line_r  <= line_nxt;
      bit_r   <= bit_nxt;
      hold_r  <= hold_nxt;
    end
  end

  always_comb begin
    phase_nxt    = phase_r;
    line_nxt     = line_r;
    bit_nxt      = bit_r;
    hold_nxt     = hold_r;
    go_next_line = 1'b0;
    rd_en        = 1'b0;
    hold_inc     = hold_r + 1'b1;
    last_line    = (line_r == LINE_W'(LINE_COUNT - 1));
    res.rows        = ~line_r;
    res.shift       = 1'b0;
    res.latch       = 1'b0;
    res.blank       = 1'b1;
    res.plane       = bit_r[BIT_W-1 -: PLANE_W];
    res.entry_valid = ent_valid_r[rd_addr];
    unique case (phase_r)
      PH_SHIFT: begin
        res.shift = 1'b1;
        rd_en     = tick;
        bit_nxt   = bit_r + 1'b1;
        if (bit_r == BIT_W'(BITS_IN_LINE - 1)) begin
          phase_nxt = PH_LATCH;
        end
      end
      PH_LATCH: begin
        res.latch = 1'b1;
        hold_nxt  = '0;
        if (hold_ticks_r == '0) begin
          go_next_line = 1'b1;
        end else begin
          phase_nxt = PH_HOLD;
        end
      end
      PH_HOLD: begin
        res.blank = 1'b0;
        hold_nxt  = hold_inc;
        if ((hold_inc >= hold_ticks_r) || (hold_inc == '0)) begin
          go_next_line = 1'b1;
        end
      end
      PH_END: begin
        res.rows  = '1;
        line_nxt  = '0;
        bit_nxt   = '0;
        hold_nxt  = '0;
        phase_nxt = PH_SHIFT;
      end
    endcase
    if (go_next_line) begin
      line_nxt  = last_line ? '0 : line_r + 1'b1;
      bit_nxt   = '0;
      hold_nxt  = '0;
      phase_nxt = last_line ? PH_END : PH_SHIFT;
    end
  end

  assign s1_adv    = s1_v_r && (!out_v_r || out_tready);
  assign in_tready = !s1_v_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (tick) begin
      s1_v_r <= 1'b1;
    end else if (s1_adv) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tick) begin
      s1_res_r <= res;
    end
  end

  assign serial = s1_res_r.shift && s1_res_r.entry_valid &&
                  ram_rdata[s1_res_r.plane];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s1_adv) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_data_r <= {1'b0, s1_res_r.blank, s1_res_r.latch, s1_res_r.shift,
                     serial, s1_res_r.rows};
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;

endmodule

### rtl/core/lmsd_checker.sv
// Port-level checker for the LED matrix scan driver, bound to its top level.
// Depends on led_matrix_scan_driver_core_defines.svh and the top level's ports.
`include "led_matrix_scan_driver_core_defines.svh"

module lmsd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [7:0]  out_tdata
);

  logic stall;
  logic sdata;
  logic sclk;
  logic latch;
  logic blank;

  assign stall = out_tvalid && !out_tready;
  assign sdata = out_tdata[3];
  assign sclk  = out_tdata[4];
  assign latch = out_tdata[5];
  assign blank = out_tdata[6];

  `LMSD_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_tvalid, "result valid after reset")

  `LMSD_ASSERT_CLK(a_out_hold, stall |=> out_tvalid && $stable(out_tdata), "result not held")

  `LMSD_ASSERT_CLK(a_shift_blank, out_tvalid && sclk |-> blank && !latch, "shift tick lit")

  `LMSD_ASSERT_CLK(a_data_shift, out_tvalid && !sclk |-> !sdata, "data outside shift")

  `LMSD_ASSERT_CLK(a_lit_quiet, out_tvalid && !blank |-> !latch && !sclk, "display tick busy")

endmodule

bind led_matrix_scan_driver_core lmsd_checker u_lmsd_checker (.*);

### bench/tb_led_matrix_scan_driver_core.sv
// Self-checking bench for led_matrix_scan_driver_core: random pixel writes, clears and
// scan ticks, with every tick's pin levels checked against an in-bench scan model.
// Depends on lmsd_pkg and the RTL of the core.
`timescale 1ns / 100ps

module tb_led_matrix_scan_driver_core;
  import lmsd_pkg::*;

  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam int         CYCLE_LIMIT = 400000;
  localparam int         NUM_PHASES  = 9;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] x;
    logic [7:0] y;
    logic [2:0] colour;
  } pixel_req_t;

  typedef struct packed {
    logic [2:0] rows;
    logic       serial;
    logic       sclk;
    logic       latch;
    logic       blank;
  } pin_levels_t;

  logic                clk         = 1'b0;
  logic                rst_n       = 1'b0;
  logic                in_tvalid   = 1'b0;
  logic                in_tready;
  logic [1:0]          in_tuser    = '0;
  logic [23:0]         in_tdata    = '0;
  logic                out_tvalid;
  logic                out_tready  = 1'b0;
  logic [7:0]          out_tdata;
  logic                cfg_psel    = 1'b0;
  logic                cfg_penable = 1'b0;
  logic                cfg_pwrite  = 1'b0;
  logic [CFG_AW-1:0]   cfg_paddr   = '0;
  logic [CFG_DW-1:0]   cfg_pwdata  = '0;
  logic [CFG_DW-1:0]   cfg_prdata;
  logic                cfg_pready;

  pixel_req_t  request_q[$];
  pin_levels_t pin_levels_q[$];
  pixel_req_t  driven_req;
  pixel_req_t  next_req;
  pin_levels_t want;

  // Scan model state.
  logic          frame_store[LINE_COUNT*BITS_IN_LINE];
  logic [3:0]    scan_line;
  int            bit_pos;
  logic [15:0]   lit_count;
  phase_t        scan_phase;
  logic [15:0]   hold_ticks;

  int in_gap        = 0;
  int out_stall     = 0;
  int hold_off_left = 0;
  bit held_off      = 1'b0;
  int in_idle_pct   = 25;
  int out_stall_pct = 25;
  int results_seen  = 0;
  int mismatches    = 0;
  int cycles        = 0;

  led_matrix_scan_driver_core u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tuser    (in_tuser),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic int pick_gap(int pct);
    if ($urandom_range(99) >= pct) return 0;
    if ($urandom_range(9) < 8) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  task automatic advance_line();
    scan_line  = scan_line + 4'd1;
    bit_pos    = 0;
    lit_count  = '0;
    scan_phase = (scan_line >= LINE_COUNT) ? PH_END : PH_SHIFT;
  endtask

  task automatic apply_request(input pixel_req_t r);
    int          col;
    int          base;
    pin_levels_t p;
    case (r.op)
      OP_WRITE: begin
        if (r.x <= 8'd15 && r.y <= 8'd15) begin
          col  = r.x + (r.y[0] ? 16 : 0);
          base = (r.y / 2) * BITS_IN_LINE + col;
          frame_store[base]                = r.colour[1];
          frame_store[base + PLANE_COLS]   = r.colour[2];
          frame_store[base + 2*PLANE_COLS] = r.colour[0];
        end
      end
      OP_CLEAR: begin
        foreach (frame_store[i]) frame_store[i] = 1'b0;
      end
      OP_TICK: begin
        p = '{rows: ~scan_line[2:0], serial: 1'b0, sclk: 1'b0, latch: 1'b0, blank: 1'b1};
        case (scan_phase)
          PH_SHIFT: begin
            p.serial = frame_store[scan_line*BITS_IN_LINE + bit_pos];
            p.sclk   = 1'b1;
            bit_pos++;
            if (bit_pos >= BITS_IN_LINE) scan_phase = PH_LATCH;
          end
          PH_LATCH: begin
            p.latch   = 1'b1;
            lit_count = '0;
            if (hold_ticks == 16'd0) advance_line();
            else scan_phase = PH_HOLD;
          end
          PH_HOLD: begin
            p.blank   = 1'b0;
            lit_count = lit_count + 16'd1;
            if (lit_count >= hold_ticks || lit_count == 16'd0) advance_line();
          end
          default: begin
            p.rows     = 3'd7;
            scan_line  = '0;
            bit_pos    = 0;
            lit_count  = '0;
            scan_phase = PH_SHIFT;
          end
        endcase
        pin_levels_q.push_back(p);
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_gap    <= 0;
    end else begin
      if (in_tvalid && in_tready) apply_request(driven_req);
      if (!in_tvalid || in_tready) begin
        if (in_gap > 0) begin
          in_gap    <= in_gap - 1;
          in_tvalid <= 1'b0;
        end else if (request_q.size() > 0) begin
          next_req   = request_q.pop_front();
          driven_req <= next_req;
          in_tvalid  <= 1'b1;
          in_tuser   <= next_req.op;
          in_tdata   <= {5'b0, next_req.colour, next_req.y, next_req.x};
          in_gap     <= pick_gap(in_idle_pct);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (pin_levels_q.size() == 0) begin
          $error("result with none expected: out_tdata %h", out_tdata);
          mismatches++;
        end else begin
          want = pin_levels_q.pop_front();
          results_seen++;
          if (out_tdata[2:0] !== want.rows) begin
            $error("row_pins: expected %0d, got %0d", want.rows, out_tdata[2:0]);
            mismatches++;
          end
          if (out_tdata[3] !== want.serial) begin
            $error("serial_data: expected %0d, got %0d", want.serial, out_tdata[3]);
            mismatches++;
          end
          if (out_tdata[4] !== want.sclk) begin
            $error("shift_clock: expected %0d, got %0d", want.sclk, out_tdata[4]);
            mismatches++;
          end
          if (out_tdata[5] !== want.latch) begin
            $error("latch_pulse: expected %0d, got %0d", want.latch, out_tdata[5]);
            mismatches++;
          end
          if (out_tdata[6] !== want.blank) begin
            $error("blank: expected %0d, got %0d", want.blank, out_tdata[6]);
            mismatches++;
          end
        end
      end
      if (!held_off && results_seen >= 150) begin
        held_off      = 1'b1;
        hold_off_left = 400;
      end
      if (hold_off_left > 0) begin
        hold_off_left--;
        out_tready <= 1'b0;
      end else if (out_stall > 0) begin
        out_stall--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        out_stall = pick_gap(out_stall_pct);
      end
    end
  end

  function automatic pixel_req_t make_req(logic [1:0] op, int x, int y, int c);
    pixel_req_t r;
    r.op     = op;
    r.x      = x[7:0];
    r.y      = y[7:0];
    r.colour = c[2:0];
    return r;
  endfunction

  function automatic pixel_req_t random_req();
    pixel_req_t r;
    int         pick;
    pick     = $urandom_range(99);
    r.x      = 8'($urandom_range(255));
    r.y      = 8'($urandom_range(255));
    r.colour = 3'($urandom_range(7));
    if (pick < 85) begin
      r.op = OP_TICK;
    end else if (pick < 96) begin
      r.op = OP_WRITE;
      if ($urandom_range(4) != 0) begin
        r.x = 8'($urandom_range(15));
        r.y = 8'($urandom_range(15));
      end
    end else if (pick < 97) begin
      r.op = OP_CLEAR;
    end else begin
      r.op = OP_UNUSED;
    end
    return r;
  endfunction

  task automatic wait_drained();
    while (request_q.size() != 0 || in_tvalid || pin_levels_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic check_hold_readback(input logic [15:0] v);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= REG_HOLD_TICKS;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    if (cfg_prdata !== {16'b0, v}) begin
      $error("hold_ticks readback: expected %0d, got %0d", v, cfg_prdata);
      mismatches++;
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_hold_ticks(input logic [15:0] v);
    wait_drained();
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= REG_HOLD_TICKS;
    cfg_pwdata  <= {16'b0, v};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    hold_ticks = v;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    check_hold_readback(v);
  endtask

  initial begin
    int          phase_len[NUM_PHASES];
    logic [15:0] phase_hold[NUM_PHASES];
    foreach (frame_store[i]) frame_store[i] = 1'b0;
    scan_line  = '0;
    bit_pos    = 0;
    lit_count  = '0;
    scan_phase = PH_SHIFT;
    hold_ticks = HOLD_RESET;
    phase_len  = '{120, 180, 110, 110, 110, 110, 110, 110, 90};
    phase_hold = '{16'd0, 16'd65535, 16'd2, 16'd0, 16'd1, 16'd0, 16'd0, 16'd0, 16'd3};

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    check_hold_readback(HOLD_RESET);

    request_q.push_back(make_req(OP_WRITE, 0, 0, 7));
    request_q.push_back(make_req(OP_WRITE, 15, 15, 7));
    request_q.push_back(make_req(OP_WRITE, 15, 0, 2));
    request_q.push_back(make_req(OP_WRITE, 0, 15, 4));
    request_q.push_back(make_req(OP_WRITE, 7, 8, 1));
    request_q.push_back(make_req(OP_WRITE, 16, 0, 7));
    request_q.push_back(make_req(OP_WRITE, 0, 16, 7));
    request_q.push_back(make_req(OP_WRITE, 255, 255, 7));
    request_q.push_back(make_req(OP_UNUSED, 255, 255, 7));
    repeat (4) request_q.push_back(make_req(OP_TICK, 0, 0, 0));
    request_q.push_back(make_req(OP_CLEAR, 170, 85, 5));
    repeat (2) request_q.push_back(make_req(OP_TICK, 255, 255, 7));
    request_q.push_back(make_req(OP_WRITE, 0, 0, 7));
    request_q.push_back(make_req(OP_WRITE, 5, 0, 7));
    request_q.push_back(make_req(OP_WRITE, 6, 0, 2));
    request_q.push_back(make_req(OP_WRITE, 3, 1, 5));
    request_q.push_back(make_req(OP_WRITE, 12, 6, 3));
    repeat (3) request_q.push_back(make_req(OP_TICK, 0, 0, 0));

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph == 6) phase_hold[ph] = 16'($urandom_range(9));
      write_hold_ticks(phase_hold[ph]);
      in_idle_pct   = (ph % 3 == 1 || ph == NUM_PHASES - 1) ? 0 : 25;
      out_stall_pct = (ph % 3 == 2 || ph == NUM_PHASES - 1) ? 0 : 25;
      for (int k = 0; k < phase_len[ph]; k++) request_q.push_back(random_req());
    end

    wait_drained();
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
